// ===== hdl/wtapl_pkg.sv =====
// wtapl_pkg: shared types and constants for the prototype learner
// used by wtapl_ctrl, wtapl_dpath and winner_take_all_prototype_learner
package wtapl_pkg;
  localparam int NEURONS_DEF = 3;
  localparam int FEATURES_DEF = 4;
  localparam int FRAC_BITS_DEF = 12;
  localparam int MAX_FEATURES = 4;
  localparam int W_W = 16;
  localparam int DIST_W = 36;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0, OP_TRAIN = 2'd1, OP_CLASSIFY = 2'd2, OP_NOP = 2'd3
  } opcode_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;     // latch input transaction
    logic load_wr;     // write loaded vector
    logic dist_start;  // clear search
    logic dist_step;   // one neuron distance
    logic upd_step;    // one element learning update
    logic sq_step;     // accumulate one square
    logic sqrt_init;
    logic sqrt_step;
    logic div_init;    // start division for one element
    logic div_step;
    logic div_wr;      // write divided element
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last_neuron;
    logic last_elem;
    logic sqrt_done;
    logic div_done;
    logic norm_zero;
  } stat_t;
endpackage

// ===== hdl/wtapl_ctrl.sv =====
// wtapl_ctrl: sequencing state machine of the prototype learner
// depends on wtapl_pkg
module wtapl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_op,
  input  logic            out_free,
  input  wtapl_pkg::stat_t st,
  output wtapl_pkg::cmd_t cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_DIST, S_OUT, S_UPD, S_SQ, S_SQRT, S_DIVI, S_DIV, S_DIVW
  } state_t;
  state_t state;
  logic [1:0] op;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.capture = in_valid;
        cmd.dist_start = in_valid;
      end
      S_DIST: cmd.dist_step = 1'b1;
      S_OUT: begin
        cmd.out_load = out_free;
        cmd.load_wr = out_free && (op == wtapl_pkg::OP_LOAD);
      end
      S_UPD: cmd.upd_step = 1'b1;
      S_SQ: begin
        cmd.sq_step = 1'b1;
        cmd.sqrt_init = st.last_elem;
      end
      S_SQRT: cmd.sqrt_step = 1'b1;
      S_DIVI: cmd.div_init = 1'b1;
      S_DIV: cmd.div_step = 1'b1;
      S_DIVW: cmd.div_wr = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          op <= in_op;
          if (in_op == wtapl_pkg::OP_TRAIN || in_op == wtapl_pkg::OP_CLASSIFY)
            state <= S_DIST;
          else
            state <= S_OUT;
        end
        S_DIST: if (st.last_neuron) state <= S_OUT;
        S_OUT: if (out_free) state <= (op == wtapl_pkg::OP_TRAIN) ? S_UPD : S_IDLE;
        S_UPD: if (st.last_elem) state <= S_SQ;
        S_SQ: if (st.last_elem) state <= S_SQRT;
        S_SQRT: if (st.sqrt_done) state <= st.norm_zero ? S_IDLE : S_DIVI;
        S_DIVI: state <= S_DIV;
        S_DIV: if (st.div_done) state <= S_DIVW;
        S_DIVW: state <= st.last_elem ? S_IDLE : S_DIVI;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> in_stall) else $error("accepted during divide");
  a_no_two_cmd: assert property (@(posedge clk) disable iff (rst)
    !(cmd.div_step && cmd.sqrt_step)) else $error("shared steps overlap");
  a_out_once: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> !cmd.out_load) else $error("double result");
`endif
endmodule

// ===== hdl/wtapl_dpath.sv =====
// wtapl_dpath: weight store, distance search, update, sqrt and divider
// depends on wtapl_pkg
module wtapl_dpath #(
  parameter int NEURONS = wtapl_pkg::NEURONS_DEF,
  parameter int FEATURES = wtapl_pkg::FEATURES_DEF,
  parameter int FRAC_BITS = wtapl_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  wtapl_pkg::cmd_t     cmd,
  output wtapl_pkg::stat_t    st,
  input  logic [2:0]          in_sel,
  input  logic signed [15:0]  in_f [wtapl_pkg::MAX_FEATURES],
  input  logic [15:0]         in_rate,
  output logic [2:0]          res_winner,
  output logic [35:0]         res_dist
);
  localparam int NW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int FW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int SQ_W = 36;                  // sum of four 32-bit squares
  localparam int RT_W = SQ_W / 2;
  localparam int NUM_W = 16 + FRAC_BITS;     // magnitude << FRAC_BITS
  localparam int QW = NUM_W + 1;

  logic signed [15:0] wmem [NEURONS][FEATURES];
  logic signed [15:0] x [wtapl_pkg::MAX_FEATURES];
  logic [2:0] sel;
  logic [15:0] rate;
  logic [NW-1:0] ncnt, best;
  logic [FW-1:0] ecnt;
  logic [37:0] bestd;

  // distance of neuron ncnt: features in parallel
  logic [37:0] dsum;
  always_comb begin
    logic signed [16:0] d;
    logic [33:0] sq;
    dsum = '0;
    for (int i = 0; i < FEATURES; i++) begin
      d = 17'(x[i]) - 17'(wmem[ncnt][i]);
      sq = 34'($signed(d) * $signed(d));
      dsum = dsum + 38'(sq);
    end
  end

  // learning step on one element
  logic signed [15:0] wcur;
  logic signed [16:0] diff;
  logic signed [34:0] prod;
  logic signed [18:0] wnew;
  logic signed [15:0] wsat;
  always_comb begin
    wcur = wmem[best][ecnt];
    diff = 17'(x[ecnt]) - 17'(wcur);
    prod = $signed({1'b0, rate}) * diff + 35'sd32768;
    wnew = 19'(wcur) + 19'(prod >>> 16);
    if (wnew > 19'sd32767) wsat = 16'sh7fff;
    else if (wnew < -19'sd32768) wsat = 16'sh8000;
    else wsat = wnew[15:0];
  end

  logic [SQ_W-1:0] sumsq, rem_s;
  logic [RT_W-1:0] root;
  logic [4:0] scnt;
  logic [NUM_W-1:0] dividend;
  logic [QW-1:0] quot;
  logic [RT_W:0] drem;
  logic [5:0] dcnt;
  logic wneg;
  logic [31:0] wsq;
  assign wsq = 32'($signed(wcur) * $signed(wcur));

  // sqrt trial
  logic [SQ_W+1:0] trial, shrem;
  assign shrem = {rem_s[SQ_W-1:0], sumsq[SQ_W-1 -: 2]};
  assign trial = 38'({root, 2'b01});
  // divide trial (rounded: (mag + norm/2)/norm)
  logic [RT_W:0] dsh;
  assign dsh = {drem[RT_W-1:0], dividend[NUM_W-1]};

  logic signed [QW:0] sq_val;
  always_ff @(posedge clk) begin
    if (rst) begin
      ncnt <= '0;
      ecnt <= '0;
    end else begin
      if (cmd.capture) begin
        sel <= in_sel;
        rate <= in_rate;
        x <= in_f;
      end
      if (cmd.dist_start) ncnt <= '0;
      if (cmd.dist_step) begin
        if (ncnt == '0 || dsum < bestd) begin
          bestd <= dsum;
          best <= ncnt;
        end
        ncnt <= ncnt + 1'b1;
      end
      if (cmd.load_wr && {1'b0, sel} < 4'(NEURONS))
        for (int i = 0; i < FEATURES; i++) wmem[sel[NW-1:0]][i] <= x[i];
      if (cmd.upd_step) begin
        wmem[best][ecnt] <= wsat;
        ecnt <= (ecnt == FW'(FEATURES-1)) ? '0 : ecnt + 1'b1;
        sumsq <= '0;
      end
      if (cmd.sq_step) begin
        sumsq <= sumsq + SQ_W'(wsq);
        ecnt <= (ecnt == FW'(FEATURES-1)) ? '0 : ecnt + 1'b1;
      end
      if (cmd.sqrt_init) begin
        root <= '0;
        rem_s <= '0;
        scnt <= '0;
      end
      if (cmd.sqrt_step) begin
        sumsq <= sumsq << 2;
        scnt <= scnt + 1'b1;
        if (shrem >= trial) begin
          rem_s <= SQ_W'(shrem - trial);
          root <= {root[RT_W-2:0], 1'b1};
        end else begin
          rem_s <= SQ_W'(shrem);
          root <= {root[RT_W-2:0], 1'b0};
        end
      end
      if (cmd.div_init) begin
        wneg <= wcur[15];
        dividend <= NUM_W'({(wcur[15] ? 16'(-wcur) : 16'(wcur)), FRAC_BITS'(0)})
                    + NUM_W'(root >> 1);
        drem <= '0;
        quot <= '0;
        dcnt <= '0;
      end
      if (cmd.div_step) begin
        dividend <= dividend << 1;
        dcnt <= dcnt + 1'b1;
        if (dsh >= {1'b0, root}) begin
          drem <= dsh - {1'b0, root};
          quot <= {quot[QW-2:0], 1'b1};
        end else begin
          drem <= dsh;
          quot <= {quot[QW-2:0], 1'b0};
        end
      end
      if (cmd.div_wr) begin
        wmem[best][ecnt] <= sq_val > 18'sd32767 ? 16'sh7fff :
                            sq_val < -18'sd32768 ? 16'sh8000 : sq_val[15:0];
        ecnt <= (ecnt == FW'(FEATURES-1)) ? '0 : ecnt + 1'b1;
      end
    end
  end
  assign sq_val = wneg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  assign st.last_neuron = (ncnt == NW'(NEURONS-1));
  assign st.last_elem = (ecnt == FW'(FEATURES-1));
  assign st.sqrt_done = (scnt == 5'(RT_W-1));
  assign st.div_done = (dcnt == 6'(NUM_W-1));
  // root including the bit settled on the final step
  assign st.norm_zero = (root[RT_W-2:0] == '0) && (shrem < trial);
  assign res_winner = 3'(best);
  assign res_dist = (bestd > 38'h0fffffffff) ? 36'hfffffffff : bestd[35:0];
endmodule

// ===== hdl/winner_take_all_prototype_learner.sv =====
// winner_take_all_prototype_learner: competitive-learning top level
// load and classify end once the result is written out; train adds
// update pass, sum of squares, sqrt (one root bit a cycle), divide
// per element (one quotient bit a cycle); one transaction at a time
// result held in an output register until taken; rst is synchronous,
// clears control state only, the weight store is undefined until loaded
module winner_take_all_prototype_learner #(
  parameter int NEURONS = wtapl_pkg::NEURONS_DEF,
  parameter int FEATURES = wtapl_pkg::FEATURES_DEF,
  parameter int FRAC_BITS = wtapl_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [2:0]  neuron_sel,
  input  logic signed [15:0] feature_0,
  input  logic signed [15:0] feature_1,
  input  logic signed [15:0] feature_2,
  input  logic signed [15:0] feature_3,
  input  logic [15:0] learn_rate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  winner,
  output logic [35:0] best_distance
);
  wtapl_pkg::cmd_t cmd;
  wtapl_pkg::stat_t st;
  logic [2:0] res_winner;
  logic [35:0] res_dist;
  logic [1:0] op;
  logic signed [15:0] f [wtapl_pkg::MAX_FEATURES];
  assign f[0] = feature_0;
  assign f[1] = feature_1;
  assign f[2] = feature_2;
  assign f[3] = feature_3;

  // output slot free when empty or being taken this cycle
  logic out_free;
  assign out_free = !out_valid || !out_stall;

  wtapl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_op(opcode), .out_free(out_free), .st(st), .cmd(cmd)
  );

  wtapl_dpath #(.NEURONS(NEURONS), .FEATURES(FEATURES), .FRAC_BITS(FRAC_BITS)) u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st), .in_sel(neuron_sel), .in_f(f),
    .in_rate(learn_rate), .res_winner(res_winner), .res_dist(res_dist)
  );

  // remember opcode for the result: load and no-op report zero
  always_ff @(posedge clk) begin
    if (rst) op <= '0;
    else if (cmd.capture) op <= opcode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
        if (op == wtapl_pkg::OP_TRAIN || op == wtapl_pkg::OP_CLASSIFY) begin
          winner <= res_winner;
          best_distance <= res_dist;
        end else begin
          winner <= '0;
          best_distance <= '0;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(best_distance))
    else $error("result dropped under stall");
  a_load_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load && op == wtapl_pkg::OP_LOAD |=> winner == '0)
    else $error("load reported winner");
  a_out_ovw: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free) else $error("result overwritten");
`endif
endmodule
